// ----- hw/rtl/pees_pkg.sv -----
// Shared types and constants for the prefix expression stack evaluator.
// No dependencies; the files that use it refer to it by scoped names.
package pees_pkg;

  localparam int unsigned WORD_W   = 32;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned OPCODE_W = 2;

  // token kinds
  localparam logic KIND_OPERAND  = 1'b0;
  localparam logic KIND_OPERATOR = 1'b1;

  // operator codes
  localparam logic [OPCODE_W-1:0] OP_ADD = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_SUB = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_MUL = 2'd2;
  localparam logic [OPCODE_W-1:0] OP_DIV = 2'd3;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 3'd1;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_DIVZERO   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_LEFTOVER  = 3'd4;

  // sequencer to arithmetic unit
  typedef struct packed {
    logic                start;
    logic [OPCODE_W-1:0] op;
  } alu_req_t;

  // arithmetic unit back to sequencer
  typedef struct packed {
    logic done;
    logic div_zero;
  } alu_rsp_t;

endpackage

// ----- hw/rtl/pees_token_if.sv -----
// Token request channel: valid/ready handshake with the token fields.
// Depends on pees_pkg for field widths.
interface pees_token_if;
  logic                               valid;
  logic                               ready;
  logic                               kind;
  logic signed [pees_pkg::WORD_W-1:0] operand_value;
  logic [pees_pkg::OPCODE_W-1:0]      operator_code;
  logic                               last_token;

  modport source (output valid, kind, operand_value, operator_code, last_token, input ready);
  modport sink   (input valid, kind, operand_value, operator_code, last_token, output ready);
endinterface

// ----- hw/rtl/pees_result_if.sv -----
// Result request channel: valid/ready handshake with value and status.
// Depends on pees_pkg for field widths.
interface pees_result_if;
  logic                               valid;
  logic                               ready;
  logic signed [pees_pkg::WORD_W-1:0] result_value;
  logic [pees_pkg::STATUS_W-1:0]      status;

  modport source (output valid, result_value, status, input ready);
  modport sink   (input valid, result_value, status, output ready);
endinterface

// ----- hw/rtl/pees_stack.sv -----
// Value stack storage: one write port, one registered read port.
// No package dependencies.
module pees_stack #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [31:0]              wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [31:0]              rd_data
);

  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- hw/rtl/pees_alu.sv -----
// Shared arithmetic unit: add, subtract, multiply with a registered result, signed
// truncating divide by restoring radix-2 iteration. Depends on pees_pkg.
module pees_alu (
  input  logic                     clk,
  input  logic                     rst,
  input  pees_pkg::alu_req_t       req,
  input  logic [31:0]              a,
  input  logic [31:0]              b,
  output pees_pkg::alu_rsp_t       rsp,
  output logic [31:0]              result
);

  logic        busy;
  logic [4:0]  count;
  logic [31:0] rem;
  logic [31:0] quo;
  logic [31:0] divisor;
  logic        neg;

  logic [31:0] a_mag;
  logic [31:0] b_mag;
  logic [32:0] shifted;
  logic [32:0] trial;
  logic [31:0] rem_next;
  logic [31:0] quo_next;
  logic        done_next;
  logic        div_zero_next;

  assign a_mag = a[31] ? (32'd0 - a) : a;
  assign b_mag = b[31] ? (32'd0 - b) : b;

  // one quotient bit per cycle
  assign shifted = {rem, quo[31]};
  assign trial   = shifted - {1'b0, divisor};

  always_comb begin
    if (!trial[32]) begin
      rem_next = trial[31:0];
      quo_next = {quo[30:0], 1'b1};
    end else begin
      rem_next = shifted[31:0];
      quo_next = {quo[30:0], 1'b0};
    end
  end

  always_comb begin
    done_next     = 1'b0;
    div_zero_next = 1'b0;
    if (req.start) begin
      if (req.op != pees_pkg::OP_DIV) begin
        done_next = 1'b1;
      end else if (b == 32'd0) begin
        done_next     = 1'b1;
        div_zero_next = 1'b1;
      end
    end else if (busy && (count == 5'd31)) begin
      done_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy         <= 1'b0;
      count        <= '0;
      rsp.done     <= 1'b0;
      rsp.div_zero <= 1'b0;
    end else begin
      rsp.done     <= done_next;
      rsp.div_zero <= div_zero_next;
      if (req.start) begin
        case (req.op)
          pees_pkg::OP_ADD: begin
            result <= a + b;
          end
          pees_pkg::OP_SUB: begin
            result <= a - b;
          end
          pees_pkg::OP_MUL: begin
            result <= a * b;
          end
          default: begin
            if (b == 32'd0) begin
              result <= 32'd0;
            end else begin
              busy    <= 1'b1;
              count   <= '0;
              rem     <= 32'd0;
              quo     <= a_mag;
              divisor <= b_mag;
              neg     <= a[31] ^ b[31];
            end
          end
        endcase
      end else if (busy) begin
        rem   <= rem_next;
        quo   <= quo_next;
        count <= count + 5'd1;
        if (count == 5'd31) begin
          busy   <= 1'b0;
          result <= neg ? (32'd0 - quo_next) : quo_next;
        end
      end
    end
  end

endmodule

// ----- hw/rtl/prefix_expression_stack_evaluator_core.sv -----
// Prefix expression evaluator top level: token sequencer, value stack and
// result register. Depends on pees_pkg, pees_token_if, pees_result_if,
// pees_stack and pees_alu.
//
//  channel | dir | fields                                         | accepted when
//  tok     | in  | kind, operand_value, operator_code, last_token | valid & ready
//  res     | out | result_value, status                           | valid & ready
//
// Operand token: pushed in S_IDLE. Add, subtract, multiply: stack read,
// execute, write back. Divide: as the others, but execute runs the 32 steps
// of the radix-2 divider. A last token then passes S_FIN to load the result.
// tok.ready is low while a token is in progress. A stalled result waits in
// its register and only holds up the next expression end, not other tokens.
// Synchronous reset empties the stack and clears the error; no sweep.
module prefix_expression_stack_evaluator_core #(
  parameter int unsigned STACK_DEPTH = 64
) (
  input  logic          clk,
  input  logic          rst,
  pees_token_if.sink    tok,
  pees_result_if.source res
);

  localparam int unsigned DW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AW = $clog2(STACK_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_WAIT,
    S_FIN
  } state_t;

  state_t                          state;
  logic [DW-1:0]                   depth;
  logic [pees_pkg::STATUS_W-1:0]   err;
  logic [31:0]                     top;
  logic [pees_pkg::OPCODE_W-1:0]   op;
  logic                            last;

  logic                            accept;
  logic [DW-1:0]                   depth_m1;
  logic [DW-1:0]                   depth_m2;
  logic                            wr_en;
  logic                            rd_en;
  logic [31:0]                     rd_data;
  pees_pkg::alu_req_t              alu_req;
  pees_pkg::alu_rsp_t              alu_rsp;
  logic [31:0]                     alu_result;
  logic                            res_free;
  logic [pees_pkg::STATUS_W-1:0]   fin_status;

  assign tok.ready = (state == S_IDLE);
  assign accept    = tok.valid && tok.ready;
  assign depth_m1  = depth - DW'(1);
  assign depth_m2  = depth - DW'(2);
  assign res_free  = !res.valid || res.ready;

  // the top of stack lives in a register; memory holds the entries below it
  assign wr_en = accept && (tok.kind == pees_pkg::KIND_OPERAND)
               && (depth != DW'(0)) && (depth < DW'(STACK_DEPTH));
  assign rd_en = accept && (tok.kind == pees_pkg::KIND_OPERATOR) && (depth >= DW'(2));

  assign alu_req.start = (state == S_READ);
  assign alu_req.op    = op;

  always_comb begin
    if (err != pees_pkg::ST_OK) begin
      fin_status = err;
    end else if (depth == DW'(0)) begin
      fin_status = pees_pkg::ST_UNDERFLOW;
    end else if (depth != DW'(1)) begin
      fin_status = pees_pkg::ST_LEFTOVER;
    end else begin
      fin_status = pees_pkg::ST_OK;
    end
  end

  pees_stack #(
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (depth_m1[AW-1:0]),
    .wr_data (top),
    .rd_en   (rd_en),
    .rd_addr (depth_m2[AW-1:0]),
    .rd_data (rd_data)
  );

  pees_alu u_alu (
    .clk    (clk),
    .rst    (rst),
    .req    (alu_req),
    .a      (top),
    .b      (rd_data),
    .rsp    (alu_rsp),
    .result (alu_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      depth     <= '0;
      err       <= pees_pkg::ST_OK;
      res.valid <= 1'b0;
    end else begin
      // in S_FIN the result register is reloaded below instead
      if (res.valid && res.ready && (state != S_FIN)) begin
        res.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            op   <= tok.operator_code;
            last <= tok.last_token;
            if (tok.kind == pees_pkg::KIND_OPERAND) begin
              if (depth >= DW'(STACK_DEPTH)) begin
                if (err == pees_pkg::ST_OK) begin
                  err <= pees_pkg::ST_OVERFLOW;
                end
              end else begin
                top   <= tok.operand_value;
                depth <= depth + DW'(1);
              end
              state <= tok.last_token ? S_FIN : S_IDLE;
            end else if (depth < DW'(2)) begin
              if (err == pees_pkg::ST_OK) begin
                err <= pees_pkg::ST_UNDERFLOW;
              end
              state <= tok.last_token ? S_FIN : S_IDLE;
            end else begin
              state <= S_READ;
            end
          end
        end
        S_READ: begin
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (alu_rsp.done) begin
            top   <= alu_result;
            depth <= depth_m1;
            if (alu_rsp.div_zero && (err == pees_pkg::ST_OK)) begin
              err <= pees_pkg::ST_DIVZERO;
            end
            state <= last ? S_FIN : S_IDLE;
          end
        end
        S_FIN: begin
          if (res_free) begin
            res.valid        <= 1'b1;
            res.result_value <= (depth != DW'(0)) ? top : 32'd0;
            res.status       <= fin_status;
            depth            <= '0;
            err              <= pees_pkg::ST_OK;
            state            <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
